// ----- hdl/b64e_pkg.sv -----
// Shared types, constants and the character table for the Base64 stream encoder.
package b64e_pkg;

   // Pad character '='
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Queue depth between group assembly and character output
   localparam int QUEUE_DEPTH = 2;

   // Slot numbers inside a group
   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;
   localparam logic [1:0] CHAR_LAST   = 2'd3;

   // Input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // Result item
   typedef struct packed {
      logic [7:0] out_char;
      logic       end_of_text;
   } rsp_type;

   // One assembled group; missing bytes are zero
   typedef struct packed {
      logic [7:0] g0;
      logic [7:0] g1;
      logic [7:0] g2;
      logic [1:0] top_slot;   // slot of the final byte (0..2)
      logic       last;
   } group_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Standard alphabet lookup for one sextet
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26)
         c = 8'h41 + {2'b00, v};
      else if (v < 6'd52)
         c = 8'h61 + {2'b00, v} - 8'd26;
      else if (v < 6'd62)
         c = 8'h30 + {2'b00, v} - 8'd52;
      else if (v == 6'd62)
         c = 8'h2B;
      else
         c = 8'h2F;
      return c;
   endfunction

endpackage

// ----- hdl/b64e_front.sv -----
// Front end: takes bytes, holds a partial group and releases full or final groups.
module b64e_front import b64e_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   input  q_status_type q_status,
   output logic         push,
   output group_type    push_group
);

   logic [7:0] held_ff [2];
   logic [7:0] held_in [2];
   logic [1:0] count_ff, count_in;
   logic [1:0] cnt;
   logic       accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // A held count of three cannot occur; fold it onto two
   assign cnt = (count_ff == 2'd3) ? SLOT_THIRD : count_ff;

   // Group build and hold update
   always_comb begin
      held_in  = held_ff;
      count_in = count_ff;
      push     = 1'b0;
      push_group.g0       = (cnt == SLOT_FIRST) ? req_data.data_byte : held_ff[0];
      push_group.g1       = (cnt == SLOT_SECOND) ? req_data.data_byte :
                            ((cnt == SLOT_THIRD) ? held_ff[1] : 8'h00);
      push_group.g2       = (cnt == SLOT_THIRD) ? req_data.data_byte : 8'h00;
      push_group.top_slot = cnt;
      push_group.last     = req_data.last_byte;
      if (accept) begin
         if (cnt != SLOT_THIRD && !req_data.last_byte) begin
            held_in[cnt[0]] = req_data.data_byte;
            count_in        = cnt + 2'd1;
         end else begin
            push       = 1'b1;
            held_in[0] = 8'h00;
            held_in[1] = 8'h00;
            count_in   = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Held bytes are only read below the fill count
   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

// ----- hdl/b64e_queue.sv -----
// Short group queue between the front end and the character output stage.
module b64e_queue import b64e_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  group_type    push_group,
   input  logic         pop,
   output group_type    head_group,
   output q_status_type q_status
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   group_type          mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign q_status.full  = (count_ff == CntW'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_group     = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

// ----- hdl/b64e_back.sv -----
// Back end: four characters per queued group, one per cycle while not stalled.
module b64e_back import b64e_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  group_type    head_group,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   group_type  cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic       can_load;
   logic [5:0] sextet;
   logic       is_pad;

   assign can_load  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Sextet for the current character
   always_comb begin
      case (idx_ff)
         2'd0:    sextet = cur_ff.g0[7:2];
         2'd1:    sextet = {cur_ff.g0[1:0], cur_ff.g1[7:4]};
         2'd2:    sextet = {cur_ff.g1[3:0], cur_ff.g2[7:6]};
         default: sextet = cur_ff.g2[5:0];
      endcase
   end

   // Character k is a pad when it lies beyond the bytes present
   assign is_pad = ({1'b0, idx_ff} > ({1'b0, cur_ff.top_slot} + 3'd1));

   // Group sequencing and output register load
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      pop = !q_status.empty &&
            (!cur_valid_ff || (can_load && idx_ff == CHAR_LAST));
      if (can_load) begin
         out_valid_in       = cur_valid_ff;
         out_in.out_char    = is_pad ? PAD_CHAR : sextet_char(sextet);
         out_in.end_of_text = cur_ff.last && (idx_ff == CHAR_LAST);
         if (cur_valid_ff) begin
            idx_in = idx_ff + 2'd1;
            if (idx_ff == CHAR_LAST)
               cur_valid_in = 1'b0;
         end
      end
      if (pop) begin
         cur_in       = head_group;
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

endmodule

// ----- hdl/base64_stream_encoder.sv -----
// Base64 stream encoder top level: front end, group queue and character output.
// Bytes are taken one transfer per cycle while the two-group queue has room; every
// third byte, or a final byte, closes a group. Each group leaves as four characters,
// one per cycle from a registered output while rsp_stall is low, so the output stage
// sets the sustained rate. A closed group passes the group queue, the current-group
// register and the output register before its first character appears. Short final
// groups are padded with '=', and the last character of a message carries
// end_of_text.
module base64_stream_encoder import b64e_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   q_status_type q_status;
   logic         push, pop;
   group_type    push_group, head_group;

   // Group assembly
   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_status   (q_status),
      .push       (push),
      .push_group (push_group)
   );

   // Group queue
   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .head_group (head_group),
      .q_status   (q_status)
   );

   // Character output
   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_group (head_group),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- hdl/b64e_checker.sv -----
// Port-level checks for the Base64 stream encoder and their bind.
module b64e_checker import b64e_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic [7:0] c;
   assign c = rsp_data.out_char;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Input side is open right after reset
   a_reset_open: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled after reset");

   // Every character is from the alphabet or a pad
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                     (c >= 8'h30 && c <= 8'h39) || c == 8'h2B || c == 8'h2F ||
                     c == PAD_CHAR))
      else $error("illegal output character");

   // A pad without end mark is followed by another pad on the next transfer
   a_pad_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && c == PAD_CHAR && !rsp_data.end_of_text
      |=> rsp_valid && c == PAD_CHAR)
      else $error("pad run broken");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- sim/base64_stream_encoder_tb.sv -----
// Self-checking testbench for the Base64 stream encoder: directed table, then random messages.
module base64_stream_encoder_tb;
   import b64e_pkg::*;

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam logic [31:0] NO_CHARS = 32'h0;
   localparam int NUM_DIRECTED = 25;
   localparam int RANDOM_ITEMS = 185;
   localparam int REPORT_LIMIT = 10;

   // One row of the directed table; chars holds four typed-in characters when typed is set
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;
      logic [31:0] chars;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Predictor state: bytes of the open group
   logic [7:0] held_byte0 = '0;
   logic [7:0] held_byte1 = '0;
   logic [1:0] held_cnt = '0;

   rsp_type      pending_chars[$];
   int           fail_count = 0;
   logic         tx_burst = 1'b0;
   logic         rx_burst = 1'b0;
   stim_row_type directed_rows [NUM_DIRECTED];

   base64_stream_encoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Encode one byte; a closed group yields four characters
   task automatic encode_step(input req_type item, output int n, output rsp_type [3:0] grp);
      logic [7:0]      g0, g1, g2;
      logic [3:0][5:0] sx;
      int              k;
      n = 0;
      grp = '0;
      if (held_cnt < 2'd2 && !item.last_byte) begin
         if (held_cnt == 2'd0)
            held_byte0 = item.data_byte;
         else
            held_byte1 = item.data_byte;
         held_cnt = held_cnt + 2'd1;
      end else begin
         // missing bytes of a short group are zero
         g0 = (held_cnt == 2'd0) ? item.data_byte : held_byte0;
         g1 = (held_cnt == 2'd1) ? item.data_byte : ((held_cnt == 2'd2) ? held_byte1 : 8'h00);
         g2 = (held_cnt == 2'd2) ? item.data_byte : 8'h00;
         sx[0] = g0[7:2];
         sx[1] = {g0[1:0], g1[7:4]};
         sx[2] = {g1[3:0], g2[7:6]};
         sx[3] = g2[5:0];
         for (k = 0; k < 4; k++) begin
            if (k <= int'(held_cnt) + 1)
               grp[k].out_char = ALPHABET[8*(63 - int'(sx[k])) +: 8];
            else
               grp[k].out_char = PAD_CHAR;
            grp[k].end_of_text = (k == 3) && item.last_byte;
         end
         n = 4;
         held_byte0 = '0;
         held_byte1 = '0;
         held_cnt = '0;
      end
   endtask

   // Offer one byte after a random gap; record what it should produce once it transfers
   task automatic send_byte(input req_type item, input logic typed, input logic [31:0] chars);
      int              gap;
      int              n;
      int              k;
      rsp_type [3:0]   grp;
      rsp_type         one;
      gap = tx_burst ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      encode_step(item, n, grp);
      if (typed) begin
         for (k = 0; k < 4; k++) begin
            one.out_char = chars[31 - 8*k -: 8];
            one.end_of_text = (k == 3) && item.last_byte;
            pending_chars = {pending_chars, one};
         end
      end else begin
         for (k = 0; k < n; k++)
            pending_chars = {pending_chars, grp[k]};
      end
      @(negedge clock);
   endtask

   // Result side: random stall before each transfer, compare against oldest expectation
   initial begin : rsp_side
      int      hold;
      int      seen;
      rsp_type want;
      seen = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (seen % 12 == 0)
            rx_burst = ($urandom_range(0, 3) == 0);
         hold = rx_burst ? 0 : $urandom_range(0, 4);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         seen++;
         if (pending_chars.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected character: char=%h eot=%b",
                        rsp_data.out_char, rsp_data.end_of_text);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_data.out_char !== want.out_char ||
                rsp_data.end_of_text !== want.end_of_text) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("mismatch: expected char=%h eot=%b, actual char=%h eot=%b",
                           want.out_char, want.end_of_text,
                           rsp_data.out_char, rsp_data.end_of_text);
            end
         end
         @(negedge clock);
      end
   end

   // Main sequence: reset, directed table, pause until drained, random messages
   initial begin : req_side
      int      i;
      int      len;
      int      items_left;
      req_type item;

      directed_rows = '{
         '{8'h00, 1'b1, 1'b1, "AA=="},   // single zero byte
         '{8'hFF, 1'b1, 1'b1, "/w=="},   // single all-ones byte
         '{8'hFF, 1'b0, 1'b0, NO_CHARS},
         '{8'hFF, 1'b1, 1'b1, "//8="},   // two-byte short group
         '{8'h00, 1'b0, 1'b0, NO_CHARS},
         '{8'h00, 1'b0, 1'b0, NO_CHARS},
         '{8'h00, 1'b0, 1'b1, "AAAA"},   // full group, not final
         '{8'hFF, 1'b0, 1'b0, NO_CHARS},
         '{8'hFF, 1'b0, 1'b0, NO_CHARS},
         '{8'hFF, 1'b1, 1'b1, "////"},   // full final group
         '{8'h4D, 1'b0, 1'b0, NO_CHARS},
         '{8'h61, 1'b0, 1'b0, NO_CHARS},
         '{8'h6E, 1'b1, 1'b1, "TWFu"},
         '{8'hFB, 1'b0, 1'b0, NO_CHARS},
         '{8'hEF, 1'b0, 1'b0, NO_CHARS},
         '{8'hBE, 1'b0, 1'b0, NO_CHARS},
         '{8'h03, 1'b0, 1'b0, NO_CHARS},
         '{8'hE0, 1'b1, 1'b0, NO_CHARS},
         '{8'h4D, 1'b0, 1'b0, NO_CHARS},
         '{8'h61, 1'b1, 1'b1, "TWE="},
         '{8'h55, 1'b0, 1'b0, NO_CHARS},
         '{8'hAA, 1'b0, 1'b0, NO_CHARS},
         '{8'h5A, 1'b0, 1'b0, NO_CHARS},
         '{8'h0F, 1'b1, 1'b0, NO_CHARS},
         '{8'h80, 1'b1, 1'b0, NO_CHARS}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      tx_burst = 1'b0;
      for (i = 0; i < NUM_DIRECTED; i++) begin
         item.data_byte = directed_rows[i].data;
         item.last_byte = directed_rows[i].last;
         send_byte(item, directed_rows[i].typed, directed_rows[i].chars);
      end

      // hold off until the encoder has drained completely
      req_valid <= 1'b0;
      wait (pending_chars.size() == 0);
      @(negedge clock);

      // random messages, mostly short, a few long
      items_left = RANDOM_ITEMS;
      while (items_left > 0) begin
         tx_burst = ($urandom_range(0, 3) == 0);
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
         for (i = 0; i < len; i++) begin
            item.data_byte = 8'($urandom_range(0, 255));
            item.last_byte = (i == len - 1);
            send_byte(item, 1'b0, NO_CHARS);
         end
         items_left -= len;
      end
      req_valid <= 1'b0;

      wait (pending_chars.size() == 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_chars.size() == 0)
         $display("base64_stream_encoder test passed");
      else
         $display("base64_stream_encoder test failed");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("base64_stream_encoder test failed");
      $finish;
   end

endmodule
